// ----- rtl/core/lpc_pkg.sv -----
// Shared types, constants and register codes for the lane point clusterer.
`timescale 1ns / 1ps
`default_nettype none

package lpc_pkg;

    localparam int MAX_LANES_DEF  = 16;
    localparam int COORD_BITS_DEF = 11;

    localparam int IN_COORD_W = 11;
    localparam int OUT_IDX_W  = 4;
    localparam int CNT_W      = 8;
    localparam int DIST_W     = 23;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 23;

    localparam logic [CNT_W-1:0]  CNT_MAX  = 8'd255;
    localparam logic [DIST_W-1:0] DIST_MAX = 23'd8388607;

    localparam logic [10:0]       CENTER_COL_RST = 11'd320;
    localparam logic [10:0]       CENTER_ROW_RST = 11'd384;
    localparam logic [DIST_W-1:0] JOIN_DIST_RST  = 23'd100;
    localparam logic [CNT_W-1:0]  MIN_POINTS_RST = 8'd5;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CENTER_COL   = 2'd0,
        REG_CENTER_ROW   = 2'd1,
        REG_JOIN_DIST_SQ = 2'd2,
        REG_MIN_POINTS   = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CPREP,
        ST_LPREP,
        ST_PASS,
        ST_DRAIN,
        ST_FINAL
    } lpc_state_t;

    // per-ring control: rotate one step, or write one cell directly
    typedef struct packed {
        logic shift;
        logic load;
    } ring_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/lpc_lane_cell.sv -----
// One lane record cell of the rotating lane ring.
`timescale 1ns / 1ps
`default_nettype none

module lpc_lane_cell
    import lpc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire ring_ctrl_t            ctrl,
    input  wire logic                  load_sel,
    // neighbor record
    input  wire logic                  in_used,
    input  wire logic [COORD_BITS-1:0] in_col,
    input  wire logic [COORD_BITS-1:0] in_row,
    input  wire logic [CNT_W-1:0]      in_cnt,
    input  wire logic [DIST_W-1:0]     in_min,
    // direct write record
    input  wire logic [COORD_BITS-1:0] ld_col,
    input  wire logic [COORD_BITS-1:0] ld_row,
    input  wire logic [CNT_W-1:0]      ld_cnt,
    input  wire logic [DIST_W-1:0]     ld_min,
    // held record
    output logic                       used,
    output logic [COORD_BITS-1:0]      col,
    output logic [COORD_BITS-1:0]      row,
    output logic [CNT_W-1:0]           cnt,
    output logic [DIST_W-1:0]          min_dist
);

    logic                  used_reg;
    logic [COORD_BITS-1:0] col_reg;
    logic [COORD_BITS-1:0] row_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIST_W-1:0]     min_reg;

    logic                  wr_load;

    assign wr_load = ctrl.load && load_sel;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
        end else if (wr_load) begin
            used_reg <= 1'b1;
        end else if (ctrl.shift) begin
            used_reg <= in_used;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_load) begin
            col_reg <= ld_col;
            row_reg <= ld_row;
            cnt_reg <= ld_cnt;
            min_reg <= ld_min;
        end else if (ctrl.shift) begin
            col_reg <= in_col;
            row_reg <= in_row;
            cnt_reg <= in_cnt;
            min_reg <= in_min;
        end
    end

    assign used     = used_reg;
    assign col      = col_reg;
    assign row      = row_reg;
    assign cnt      = cnt_reg;
    assign min_dist = min_reg;

endmodule

`default_nettype wire

// ----- rtl/core/lpc_lane_ring.sv -----
// Lane table of one side: a ring of lane cells rotating toward cell 0.
`timescale 1ns / 1ps
`default_nettype none

module lpc_lane_ring
    import lpc_pkg::*;
#(
    parameter int MAX_LANES  = MAX_LANES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int LANE_W    = $clog2(MAX_LANES)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire ring_ctrl_t            ctrl,
    // record entering the tail cell on a rotation
    input  wire logic                  tail_used,
    input  wire logic [COORD_BITS-1:0] tail_col,
    input  wire logic [COORD_BITS-1:0] tail_row,
    input  wire logic [CNT_W-1:0]      tail_cnt,
    input  wire logic [DIST_W-1:0]     tail_min,
    // direct write of a newly opened lane
    input  wire logic [LANE_W-1:0]     ld_idx,
    input  wire logic [COORD_BITS-1:0] ld_col,
    input  wire logic [COORD_BITS-1:0] ld_row,
    input  wire logic [CNT_W-1:0]      ld_cnt,
    input  wire logic [DIST_W-1:0]     ld_min,
    // head cell and the cell behind it
    output logic                       head_used,
    output logic [COORD_BITS-1:0]      head_col,
    output logic [COORD_BITS-1:0]      head_row,
    output logic [CNT_W-1:0]           head_cnt,
    output logic [DIST_W-1:0]          head_min,
    output logic [COORD_BITS-1:0]      peek_col,
    output logic [COORD_BITS-1:0]      peek_row
);

    logic                  used_w [MAX_LANES];
    logic [COORD_BITS-1:0] col_w  [MAX_LANES];
    logic [COORD_BITS-1:0] row_w  [MAX_LANES];
    logic [CNT_W-1:0]      cnt_w  [MAX_LANES];
    logic [DIST_W-1:0]     min_w  [MAX_LANES];

    for (genvar i = 0; i < MAX_LANES; i++) begin : g_cell
        logic                  n_used;
        logic [COORD_BITS-1:0] n_col;
        logic [COORD_BITS-1:0] n_row;
        logic [CNT_W-1:0]      n_cnt;
        logic [DIST_W-1:0]     n_min;

        if (i == MAX_LANES - 1) begin : g_tail
            assign n_used = tail_used;
            assign n_col  = tail_col;
            assign n_row  = tail_row;
            assign n_cnt  = tail_cnt;
            assign n_min  = tail_min;
        end else begin : g_mid
            assign n_used = used_w[i+1];
            assign n_col  = col_w[i+1];
            assign n_row  = row_w[i+1];
            assign n_cnt  = cnt_w[i+1];
            assign n_min  = min_w[i+1];
        end

        lpc_lane_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .load_sel (ld_idx == LANE_W'(i)),
            .in_used  (n_used),
            .in_col   (n_col),
            .in_row   (n_row),
            .in_cnt   (n_cnt),
            .in_min   (n_min),
            .ld_col   (ld_col),
            .ld_row   (ld_row),
            .ld_cnt   (ld_cnt),
            .ld_min   (ld_min),
            .used     (used_w[i]),
            .col      (col_w[i]),
            .row      (row_w[i]),
            .cnt      (cnt_w[i]),
            .min_dist (min_w[i])
        );
    end

    assign head_used = used_w[0];
    assign head_col  = col_w[0];
    assign head_row  = row_w[0];
    assign head_cnt  = cnt_w[0];
    assign head_min  = min_w[0];
    assign peek_col  = col_w[1];
    assign peek_row  = row_w[1];

endmodule

`default_nettype wire

// ----- rtl/core/lpc_sq_unit.sv -----
// Registered squares of the column and row differences of two points.
`timescale 1ns / 1ps
`default_nettype none

module lpc_sq_unit
    import lpc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int SQ_W      = 2 * COORD_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire logic [COORD_BITS-1:0] a_col,
    input  wire logic [COORD_BITS-1:0] a_row,
    input  wire logic [COORD_BITS-1:0] b_col,
    input  wire logic [COORD_BITS-1:0] b_row,
    output logic [SQ_W-1:0]            sq_col,
    output logic [SQ_W-1:0]            sq_row
);

    logic [COORD_BITS-1:0] dc;
    logic [COORD_BITS-1:0] dr;
    logic [SQ_W-1:0]       sq_col_reg;
    logic [SQ_W-1:0]       sq_row_reg;

    assign dc = (a_col > b_col) ? (a_col - b_col) : (b_col - a_col);
    assign dr = (a_row > b_row) ? (a_row - b_row) : (b_row - a_row);

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_col_reg <= SQ_W'(dc) * SQ_W'(dc);
            sq_row_reg <= SQ_W'(dr) * SQ_W'(dr);
        end
    end

    assign sq_col = sq_col_reg;
    assign sq_row = sq_row_reg;

endmodule

`default_nettype wire

// ----- rtl/core/lane_point_clusterer.sv -----
// Lane point clusterer: per-side lane rings, two distance heads, closest-lane tracker.
// A taken point steps through CPREP, LPREP, PASS, DRAIN and FINAL before m_tvalid rises.
// A new point is taken only in IDLE, once the last one has left FINAL; the ring of the
// point's side rotates once through the shared distance head, one lane per cycle.
// A finished result sits in the output register while the next point is taken.
// Reset (aresetn low, synchronous) clears all lane used bits and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module lane_point_clusterer
    import lpc_pkg::*;
#(
    parameter int MAX_LANES  = MAX_LANES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // point input
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [23:0]           s_tdata,  // point_col, point_row, zero pad
    input  wire logic [0:0]            s_tuser,  // side
    // result output
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,  // lane_index, closest_lane
    output logic [2:0]                 m_tuser   // opened_lane, table_full, closest_valid
);

    localparam int LANE_W = $clog2(MAX_LANES);
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int SUM_W  = SQ_W + 1;
    localparam int CMP_W  = (SUM_W > DIST_W) ? SUM_W : DIST_W;
    localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(MAX_LANES - 1);

    // configuration
    logic [10:0]       center_col_reg;
    logic [10:0]       center_row_reg;
    logic [DIST_W-1:0] join_dist_reg;
    logic [CNT_W-1:0]  min_points_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_col_reg <= CENTER_COL_RST;
            center_row_reg <= CENTER_ROW_RST;
            join_dist_reg  <= JOIN_DIST_RST;
            min_points_reg <= MIN_POINTS_RST;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CENTER_COL:   center_col_reg <= cfg_wdata[10:0];
                REG_CENTER_ROW:   center_row_reg <= cfg_wdata[10:0];
                REG_JOIN_DIST_SQ: join_dist_reg  <= cfg_wdata[DIST_W-1:0];
                REG_MIN_POINTS:   min_points_reg <= cfg_wdata[CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // control and working registers
    lpc_state_t            state_reg, state_next;
    logic                  side_reg, side_next;
    logic [COORD_BITS-1:0] pcol_reg, pcol_next;
    logic [COORD_BITS-1:0] prow_reg, prow_next;
    logic [DIST_W-1:0]     cdist_reg, cdist_next;
    logic [LANE_W-1:0]     pass_cnt_reg, pass_cnt_next;
    logic                  hit_found_reg, hit_found_next;
    logic [LANE_W-1:0]     hit_idx_reg, hit_idx_next;
    logic                  free_found_reg, free_found_next;
    logic [LANE_W-1:0]     free_idx_reg, free_idx_next;
    // tracker pipeline stage: updated record of the lane just past the head
    logic                  pl_valid_reg, pl_valid_next;
    logic                  pl_used_reg, pl_used_next;
    logic [CNT_W-1:0]      pl_cnt_reg, pl_cnt_next;
    logic [DIST_W-1:0]     pl_min_reg, pl_min_next;
    logic [LANE_W-1:0]     pl_idx_reg, pl_idx_next;
    logic                  cvalid_reg, cvalid_next;
    logic [DIST_W-1:0]     best_reg, best_next;
    logic [LANE_W-1:0]     cidx_reg, cidx_next;
    // output register
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_IDX_W-1:0]  m_lane_reg, m_lane_next;
    logic [OUT_IDX_W-1:0]  m_close_reg, m_close_next;
    logic                  m_open_reg, m_open_next;
    logic                  m_full_reg, m_full_next;
    logic                  m_cvalid_reg, m_cvalid_next;

    // ring signals
    ring_ctrl_t            ctrl0, ctrl1;
    logic                  h_used [2];
    logic [COORD_BITS-1:0] h_col  [2];
    logic [COORD_BITS-1:0] h_row  [2];
    logic [CNT_W-1:0]      h_cnt  [2];
    logic [DIST_W-1:0]     h_min  [2];
    logic [COORD_BITS-1:0] k_col  [2];
    logic [COORD_BITS-1:0] k_row  [2];

    logic                  t_used;
    logic [COORD_BITS-1:0] t_col;
    logic [COORD_BITS-1:0] t_row;
    logic [CNT_W-1:0]      t_cnt;
    logic [DIST_W-1:0]     t_min;

    // selected side
    logic                  hd_used;
    logic [COORD_BITS-1:0] hd_col;
    logic [COORD_BITS-1:0] hd_row;
    logic [CNT_W-1:0]      hd_cnt;
    logic [DIST_W-1:0]     hd_min;
    logic [COORD_BITS-1:0] pk_col;
    logic [COORD_BITS-1:0] pk_row;

    // distance heads
    logic [COORD_BITS-1:0] ccol;
    logic [COORD_BITS-1:0] crow;
    logic [SQ_W-1:0]       c_sqc, c_sqr;
    logic [SQ_W-1:0]       l_sqc, l_sqr;
    logic [COORD_BITS-1:0] lb_col, lb_row;
    logic                  c_en, l_en;
    logic [SUM_W-1:0]      c_sum, l_sum;

    logic                  is_hit;
    logic                  final_fire;
    logic                  do_open;
    logic                  take_new;

    assign ccol = COORD_BITS'(center_col_reg);
    assign crow = COORD_BITS'(center_row_reg);

    assign hd_used = h_used[side_reg];
    assign hd_col  = h_col[side_reg];
    assign hd_row  = h_row[side_reg];
    assign hd_cnt  = h_cnt[side_reg];
    assign hd_min  = h_min[side_reg];
    assign pk_col  = k_col[side_reg];
    assign pk_row  = k_row[side_reg];

    assign c_en   = (state_reg == ST_CPREP);
    assign l_en   = (state_reg == ST_LPREP) || (state_reg == ST_PASS);
    // during the pass the head unit looks one cell ahead, so the squares line up
    assign lb_col = (state_reg == ST_LPREP) ? hd_col : pk_col;
    assign lb_row = (state_reg == ST_LPREP) ? hd_row : pk_row;

    lpc_sq_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_center_sq (
        .aclk   (aclk),
        .en     (c_en),
        .a_col  (pcol_reg),
        .a_row  (prow_reg),
        .b_col  (ccol),
        .b_row  (crow),
        .sq_col (c_sqc),
        .sq_row (c_sqr)
    );

    lpc_sq_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_lane_sq (
        .aclk   (aclk),
        .en     (l_en),
        .a_col  (pcol_reg),
        .a_row  (prow_reg),
        .b_col  (lb_col),
        .b_row  (lb_row),
        .sq_col (l_sqc),
        .sq_row (l_sqr)
    );

    assign c_sum = SUM_W'(c_sqc) + SUM_W'(c_sqr);
    assign l_sum = SUM_W'(l_sqc) + SUM_W'(l_sqr);

    // head record update: first lane within join distance takes the point
    assign is_hit = (state_reg == ST_PASS) && hd_used && !hit_found_reg &&
                    (CMP_W'(l_sum) < CMP_W'(join_dist_reg));

    assign t_used = hd_used;
    assign t_col  = is_hit ? pcol_reg : hd_col;
    assign t_row  = is_hit ? prow_reg : hd_row;
    assign t_cnt  = (is_hit && (hd_cnt != CNT_MAX)) ? (hd_cnt + CNT_W'(1)) : hd_cnt;
    assign t_min  = (is_hit && (cdist_reg < hd_min)) ? cdist_reg : hd_min;

    assign final_fire = (state_reg == ST_FINAL) && (!m_valid_reg || m_tready);
    assign do_open    = !hit_found_reg && free_found_reg;

    // a freshly opened lane holds one point at the center distance of this point
    assign take_new = do_open && (min_points_reg <= CNT_W'(1)) &&
                      (!cvalid_reg || (cdist_reg < best_reg) ||
                       ((cdist_reg == best_reg) && (free_idx_reg < cidx_reg)));

    always_comb begin
        ctrl0.shift = (state_reg == ST_PASS) && !side_reg;
        ctrl1.shift = (state_reg == ST_PASS) && side_reg;
        ctrl0.load  = final_fire && do_open && !side_reg;
        ctrl1.load  = final_fire && do_open && side_reg;
    end

    for (genvar s = 0; s < 2; s++) begin : g_side
        lpc_lane_ring #(
            .MAX_LANES  (MAX_LANES),
            .COORD_BITS (COORD_BITS)
        ) u_ring (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      ((s == 0) ? ctrl0 : ctrl1),
            .tail_used (t_used),
            .tail_col  (t_col),
            .tail_row  (t_row),
            .tail_cnt  (t_cnt),
            .tail_min  (t_min),
            .ld_idx    (free_idx_reg),
            .ld_col    (pcol_reg),
            .ld_row    (prow_reg),
            .ld_cnt    (CNT_W'(1)),
            .ld_min    (cdist_reg),
            .head_used (h_used[s]),
            .head_col  (h_col[s]),
            .head_row  (h_row[s]),
            .head_cnt  (h_cnt[s]),
            .head_min  (h_min[s]),
            .peek_col  (k_col[s]),
            .peek_row  (k_row[s])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pl_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pl_valid_reg <= pl_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        side_reg       <= side_next;
        pcol_reg       <= pcol_next;
        prow_reg       <= prow_next;
        cdist_reg      <= cdist_next;
        pass_cnt_reg   <= pass_cnt_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        pl_used_reg    <= pl_used_next;
        pl_cnt_reg     <= pl_cnt_next;
        pl_min_reg     <= pl_min_next;
        pl_idx_reg     <= pl_idx_next;
        cvalid_reg     <= cvalid_next;
        best_reg       <= best_next;
        cidx_reg       <= cidx_next;
        m_lane_reg     <= m_lane_next;
        m_close_reg    <= m_close_next;
        m_open_reg     <= m_open_next;
        m_full_reg     <= m_full_next;
        m_cvalid_reg   <= m_cvalid_next;
    end

    always_comb begin
        state_next      = state_reg;
        side_next       = side_reg;
        pcol_next       = pcol_reg;
        prow_next       = prow_reg;
        cdist_next      = cdist_reg;
        pass_cnt_next   = pass_cnt_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        pl_valid_next   = 1'b0;
        pl_used_next    = t_used;
        pl_cnt_next     = t_cnt;
        pl_min_next     = t_min;
        pl_idx_next     = pass_cnt_reg;
        cvalid_next     = cvalid_reg;
        best_next       = best_reg;
        cidx_next       = cidx_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_lane_next     = m_lane_reg;
        m_close_next    = m_close_reg;
        m_open_next     = m_open_reg;
        m_full_next     = m_full_reg;
        m_cvalid_next   = m_cvalid_reg;
        s_tready        = (state_reg == ST_IDLE);

        // closest-lane tracker, one lane behind the head
        if (pl_valid_reg && pl_used_reg && (pl_cnt_reg >= min_points_reg) &&
            (!cvalid_reg || (pl_min_reg < best_reg))) begin
            cvalid_next = 1'b1;
            best_next   = pl_min_reg;
            cidx_next   = pl_idx_reg;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    side_next       = s_tuser[0];
                    pcol_next       = COORD_BITS'(s_tdata[IN_COORD_W-1:0]);
                    prow_next       = COORD_BITS'(s_tdata[2*IN_COORD_W-1:IN_COORD_W]);
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = ST_CPREP;
                end
            end
            ST_CPREP: begin
                cvalid_next = 1'b0;
                state_next  = ST_LPREP;
            end
            ST_LPREP: begin
                cdist_next    = (CMP_W'(c_sum) > CMP_W'(DIST_MAX)) ? DIST_MAX
                                                                   : DIST_W'(c_sum);
                pass_cnt_next = '0;
                state_next    = ST_PASS;
            end
            ST_PASS: begin
                pl_valid_next = 1'b1;
                if (is_hit) begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = pass_cnt_reg;
                end
                if (!hd_used && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = pass_cnt_reg;
                end
                if (pass_cnt_reg == LAST_LANE) begin
                    state_next = ST_DRAIN;
                end else begin
                    pass_cnt_next = pass_cnt_reg + LANE_W'(1);
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINAL;
            end
            ST_FINAL: begin
                if (final_fire) begin
                    m_valid_next  = 1'b1;
                    m_open_next   = do_open;
                    m_full_next   = !hit_found_reg && !free_found_reg;
                    m_lane_next   = hit_found_reg ? OUT_IDX_W'(hit_idx_reg) :
                                    do_open       ? OUT_IDX_W'(free_idx_reg) : '0;
                    m_cvalid_next = cvalid_reg || take_new;
                    m_close_next  = take_new   ? OUT_IDX_W'(free_idx_reg) :
                                    cvalid_reg ? OUT_IDX_W'(cidx_reg) : '0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_close_reg, m_lane_reg};
    assign m_tuser  = {m_cvalid_reg, m_full_reg, m_open_reg};

    // one point in flight: no transfer on the cycle after a transfer
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a point is in flight");

    a_open_full_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("result both opened a lane and reported table full");

    a_no_closest_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[2] |-> (m_tdata[7:4] == '0))
        else $error("closest lane nonzero without an eligible lane");

    // the ring must be back in place after a full rotation
    a_pass_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> (pass_cnt_reg == LAST_LANE) && $past(state_reg == ST_PASS))
        else $error("lane pass ended before a full rotation");

endmodule

`default_nettype wire
